// File: design/agfg_pkg.sv
// Package: widths, reset values, codes and control types of the audio sample conditioning chain.
`default_nettype none

package agfg_pkg;

	// Channel payload widths
	localparam int SAMPLE_W   = 16;
	localparam int BYTE_W     = 8;
	localparam int LEVEL_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// Configuration register widths
	localparam int COEF_W = 16;
	localparam int MAG_W  = 20;

	// Fixed-point format of the chain
	localparam int FRAC_BITS  = 16;
	localparam int GAIN_SHIFT = FRAC_BITS - 8;
	localparam int COEF_FRAC  = 16;
	localparam int VAL_W      = 40;
	localparam int OP_W       = VAL_W + 2;
	localparam int SPLIT      = OP_W / 2;
	localparam int MUL_A_W    = COEF_FRAC + 1;
	localparam int MUL_B_W    = SPLIT + 1;
	localparam int PROD_W     = MUL_A_W + 1 + MUL_B_W;
	localparam int ACC_W      = 60;
	localparam int PART_W     = ACC_W - COEF_FRAC;

	localparam logic [MUL_A_W-1:0] COEF_ONE = MUL_A_W'(1) << COEF_FRAC;

	localparam logic signed [ACC_W-1:0] ACC_SAT_HI = {{(ACC_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_SAT_LO = {{(ACC_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] FRAC_MASK  = {{(VAL_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

	localparam logic signed [VAL_W-1:0] RES_HI = {{(VAL_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] RES_LO = {{(VAL_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

	// Chunk peak tracking
	localparam int PEAK_W        = 15;
	localparam int SCALED_W      = PEAK_W + LEVEL_W;
	localparam int CHUNK_SAMPLES = 1024;
	localparam int CNT_W         = (CHUNK_SAMPLES > 1) ? $clog2(CHUNK_SAMPLES) : 1;
	localparam logic [PEAK_W-1:0]   PEAK_MAX   = {PEAK_W{1'b1}};
	localparam logic [SCALED_W-1:0] PEAK_DIV   = SCALED_W'(PEAK_MAX);

	// Register reset values
	localparam logic [COEF_W-1:0] GAIN_RST       = 16'd5120;
	localparam logic [COEF_W-1:0] HP_COEF_RST    = 16'd58982;
	localparam logic [COEF_W-1:0] LP_COEF_RST    = 16'd19661;
	localparam logic [MAG_W-1:0]  GATE_RST       = 20'd200;
	localparam logic [MAG_W-1:0]  KNEE_LEVEL_RST = 20'd25000;
	localparam logic [COEF_W-1:0] KNEE_SLOPE_RST = 16'd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN,
		REG_HP_COEF,
		REG_LP_COEF,
		REG_GATE,
		REG_KNEE_LEVEL,
		REG_KNEE_SLOPE
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_GAIN,
		ST_DIFF,
		ST_HP_LO,
		ST_HP_HI,
		ST_HP_ADD,
		ST_HP_END,
		ST_LP_A,
		ST_LP_B,
		ST_LP_C,
		ST_LP_END,
		ST_GATE,
		ST_KN_LO,
		ST_KN_HI,
		ST_KN_ADD,
		ST_KN_END,
		ST_TRUNC,
		ST_PEAK,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		CS_GAIN,
		CS_HP,
		CS_LP,
		CS_LP_INV,
		CS_SLOPE
	} coef_sel_t;

	typedef enum logic [1:0] {
		OS_SAMPLE,
		OS_LO,
		OS_HI
	} opnd_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD_HI
	} acc_op_t;

	typedef struct packed {
		coef_sel_t coef_sel;
		opnd_sel_t opnd_sel;
		acc_op_t   acc_op;
	} mac_ctrl_t;

	typedef struct packed {
		logic      in_ready;
		mac_ctrl_t mac;
		logic      ld_diff;
		logic      ld_op_lp;
		logic      ld_hp;
		logic      ld_part;
		logic      ld_lp;
		logic      ld_gate;
		logic      ld_knee;
		logic      ld_trunc;
		logic      peak_upd;
		logic      out_load;
	} ctrl_t;

	typedef struct packed {
		logic clear;
		logic update;
		logic finish;
	} pk_ctrl_t;

	// Saturate an accumulator-wide value to the internal value width
	function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		r = v;
		if (v > ACC_SAT_HI)
			r = ACC_SAT_HI;
		else if (v < ACC_SAT_LO)
			r = ACC_SAT_LO;
		return r[VAL_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: design/agfg_if.sv
// Interfaces: sample input channel, result output channel and configuration write channel.
`default_nettype none

interface agfg_sample_if import agfg_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] in_sample;
	logic                       restart;

	modport source(output valid, in_sample, restart, input ready);
	modport sink(input valid, in_sample, restart, output ready);
endinterface

interface agfg_result_if import agfg_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] out_sample;
	logic signed [BYTE_W-1:0]   out_byte;
	logic                       chunk_done;
	logic [LEVEL_W-1:0]         peak_level;

	modport source(output valid, out_sample, out_byte, chunk_done, peak_level, input ready);
	modport sink(input valid, out_sample, out_byte, chunk_done, peak_level, output ready);
endinterface

interface agfg_cfg_if import agfg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/agfg_mac.sv
// Shared multiply-accumulate unit: registered 18x22 signed product and a wide accumulator.
`default_nettype none

module agfg_mac import agfg_pkg::*; (
	input  logic                      clk,
	input  logic [MUL_A_W-1:0]        mul_a,
	input  logic signed [MUL_B_W-1:0] mul_b,
	input  acc_op_t                   acc_op,
	output logic signed [PROD_W-1:0]  prod,
	output logic signed [ACC_W-1:0]   acc
);

	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;

	assign prod_ext = ACC_W'(prod_q);

	always_ff @(posedge clk) begin
		prod_q <= $signed({1'b0, mul_a}) * mul_b;
		case (acc_op)
			ACC_LOAD:   acc_q <= prod_ext;
			ACC_ADD_HI: acc_q <= acc_q + (prod_ext <<< SPLIT);
			default:    acc_q <= acc_q;
		endcase
	end

	assign prod = prod_q;
	assign acc  = acc_q;

endmodule

`default_nettype wire

// File: design/agfg_ctrl.sv
// Sequencer: steps one sample through the shared multiply-accumulate unit.
`default_nettype none

module agfg_ctrl import agfg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  knee_hit,
	input  logic  out_free,
	output ctrl_t ctrl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d           = state_q;
		ctrl.in_ready     = 1'b0;
		ctrl.mac.coef_sel = CS_GAIN;
		ctrl.mac.opnd_sel = OS_SAMPLE;
		ctrl.mac.acc_op   = ACC_HOLD;
		ctrl.ld_diff      = 1'b0;
		ctrl.ld_op_lp     = 1'b0;
		ctrl.ld_hp        = 1'b0;
		ctrl.ld_part      = 1'b0;
		ctrl.ld_lp        = 1'b0;
		ctrl.ld_gate      = 1'b0;
		ctrl.ld_knee      = 1'b0;
		ctrl.ld_trunc     = 1'b0;
		ctrl.peak_upd     = 1'b0;
		ctrl.out_load     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.in_ready = 1'b1;
				if (in_valid)
					state_d = ST_GAIN;
			end
			ST_GAIN: begin
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				ctrl.ld_diff = 1'b1;
				state_d      = ST_HP_LO;
			end
			ST_HP_LO: begin
				ctrl.mac.coef_sel = CS_HP;
				ctrl.mac.opnd_sel = OS_LO;
				state_d           = ST_HP_HI;
			end
			ST_HP_HI: begin
				ctrl.mac.coef_sel = CS_HP;
				ctrl.mac.opnd_sel = OS_HI;
				ctrl.mac.acc_op   = ACC_LOAD;
				ctrl.ld_op_lp     = 1'b1;
				state_d           = ST_HP_ADD;
			end
			ST_HP_ADD: begin
				ctrl.mac.coef_sel = CS_LP_INV;
				ctrl.mac.opnd_sel = OS_LO;
				ctrl.mac.acc_op   = ACC_ADD_HI;
				state_d           = ST_HP_END;
			end
			ST_HP_END: begin
				ctrl.mac.coef_sel = CS_LP_INV;
				ctrl.mac.opnd_sel = OS_HI;
				ctrl.mac.acc_op   = ACC_LOAD;
				ctrl.ld_hp        = 1'b1;
				state_d           = ST_LP_A;
			end
			ST_LP_A: begin
				ctrl.mac.coef_sel = CS_LP;
				ctrl.mac.opnd_sel = OS_LO;
				ctrl.mac.acc_op   = ACC_ADD_HI;
				state_d           = ST_LP_B;
			end
			ST_LP_B: begin
				ctrl.mac.coef_sel = CS_LP;
				ctrl.mac.opnd_sel = OS_HI;
				ctrl.mac.acc_op   = ACC_LOAD;
				ctrl.ld_part      = 1'b1;
				state_d           = ST_LP_C;
			end
			ST_LP_C: begin
				ctrl.mac.acc_op = ACC_ADD_HI;
				state_d         = ST_LP_END;
			end
			ST_LP_END: begin
				ctrl.ld_lp = 1'b1;
				state_d    = ST_GATE;
			end
			ST_GATE: begin
				ctrl.ld_gate = 1'b1;
				state_d      = knee_hit ? ST_KN_LO : ST_TRUNC;
			end
			ST_KN_LO: begin
				ctrl.mac.coef_sel = CS_SLOPE;
				ctrl.mac.opnd_sel = OS_LO;
				state_d           = ST_KN_HI;
			end
			ST_KN_HI: begin
				ctrl.mac.coef_sel = CS_SLOPE;
				ctrl.mac.opnd_sel = OS_HI;
				ctrl.mac.acc_op   = ACC_LOAD;
				state_d           = ST_KN_ADD;
			end
			ST_KN_ADD: begin
				ctrl.mac.acc_op = ACC_ADD_HI;
				state_d         = ST_KN_END;
			end
			ST_KN_END: begin
				ctrl.ld_knee = 1'b1;
				state_d      = ST_TRUNC;
			end
			ST_TRUNC: begin
				ctrl.ld_trunc = 1'b1;
				state_d       = ST_PEAK;
			end
			ST_PEAK: begin
				ctrl.peak_upd = 1'b1;
				state_d       = ST_OUT;
			end
			ST_OUT: begin
				// hold until the output register can take the beat
				if (out_free) begin
					ctrl.out_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: design/agfg_peak.sv
// Chunk peak tracker: peak magnitude, sample count and the scaled 0..255 peak level.
`default_nettype none

module agfg_peak import agfg_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pk_ctrl_t                   ctl,
	input  logic signed [SAMPLE_W-1:0] res,
	output logic                       done,
	output logic [LEVEL_W-1:0]         level
);

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CHUNK_SAMPLES - 1);

	logic [PEAK_W-1:0]   peak_q;
	logic [CNT_W-1:0]    count_q;
	logic                done_q;
	logic [SAMPLE_W-1:0] mag_full;
	logic [PEAK_W-1:0]   mag;
	logic                last;
	logic [SCALED_W-1:0] scaled;
	logic [LEVEL_W-1:0]  q_est;
	logic [SCALED_W-1:0] q_back;
	logic [SCALED_W-1:0] rem;

	// the most negative sample counts as full scale
	assign mag_full = res[SAMPLE_W-1] ? SAMPLE_W'(-res) : SAMPLE_W'(res);
	assign mag      = mag_full[SAMPLE_W-1] ? PEAK_MAX : mag_full[PEAK_W-1:0];
	assign last     = (count_q == CNT_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else if (ctl.clear) begin
			peak_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else if (ctl.update) begin
			if (mag > peak_q)
				peak_q <= mag;
			done_q  <= last;
			count_q <= last ? '0 : count_q + CNT_W'(1);
		end else if (ctl.finish && done_q) begin
			peak_q <= '0;
		end
	end

	// peak*255 / 32767: estimate by a shift, then one correction step
	assign scaled = {peak_q, {LEVEL_W{1'b0}}} - SCALED_W'(peak_q);
	assign q_est  = scaled[SCALED_W-1:PEAK_W];
	assign q_back = {q_est, {PEAK_W{1'b0}}} - SCALED_W'(q_est);
	assign rem    = scaled - q_back;
	assign level  = (rem >= PEAK_DIV) ? q_est + LEVEL_W'(1) : q_est;
	assign done   = done_q;

endmodule

`default_nettype wire

// File: design/audio_gain_filter_gate_clip_unit.sv
// Top level: gain, high-pass, low-pass, noise gate, soft knee and chunk peak on one shared MAC.
// Only one sample is in flight: a new sample is taken only after the last result has entered
// the output register. Every product of the chain passes through the single 18x22
// multiply-accumulate unit, the filter and knee products in two halves, the gain in one.
// Reset (arst_n low, asynchronous): filter history, chunk peak and count clear, registers
// return to their defaults, and the output register empties.
`default_nettype none

module audio_gain_filter_gate_clip_unit import agfg_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	agfg_sample_if.sink   sample,
	agfg_result_if.source result,
	agfg_cfg_if.sink      cfg
);

	// Configuration registers
	logic [COEF_W-1:0] gain_q;
	logic [COEF_W-1:0] hp_coef_q;
	logic [COEF_W-1:0] lp_coef_q;
	logic [MAG_W-1:0]  gate_q;
	logic [MAG_W-1:0]  knee_q;
	logic [COEF_W-1:0] slope_q;

	// Filter history
	logic signed [VAL_W-1:0] hp_in_q;
	logic signed [VAL_W-1:0] hp_out_q;
	logic signed [VAL_W-1:0] lp_last_q;

	// Working registers of the current sample
	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [VAL_W-1:0]    s_q;
	logic signed [OP_W-1:0]     op_q;
	logic signed [PART_W-1:0]   part_q;
	logic signed [VAL_W-1:0]    v_q;
	logic                       kneg_q;
	logic signed [SAMPLE_W-1:0] res_q;

	// Output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic signed [BYTE_W-1:0]   out_byte_q;
	logic                       chunk_done_q;
	logic [LEVEL_W-1:0]         peak_level_q;

	ctrl_t                     ctrl;
	pk_ctrl_t                  pk_ctl;
	logic                      accept;
	logic                      out_free;
	logic [MUL_A_W-1:0]        mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [ACC_W-1:0]   acc;
	logic signed [ACC_W-1:0]   acc_shr;
	logic signed [VAL_W-1:0]   s_new;
	logic signed [OP_W-1:0]    diff;
	logic signed [VAL_W-1:0]   hp_new;
	logic signed [VAL_W-1:0]   lp_new;
	logic signed [OP_W-1:0]    lp_ext;
	logic signed [OP_W-1:0]    lp_abs;
	logic signed [OP_W-1:0]    thr;
	logic signed [OP_W-1:0]    knee;
	logic                      gated;
	logic                      hit_pos;
	logic                      hit_neg;
	logic                      knee_hit;
	logic signed [OP_W-1:0]    knee_base;
	logic signed [VAL_W-1:0]   knee_new;
	logic signed [VAL_W-1:0]   trunc_bias;
	logic signed [VAL_W-1:0]   trunc_val;
	logic signed [SAMPLE_W-1:0] res_new;
	logic                      pk_done;
	logic [LEVEL_W-1:0]        pk_level;

	// ---------------------------------------------------------------
	// Configuration port: always ready, writes beyond the list drop
	// ---------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= GAIN_RST;
			hp_coef_q <= HP_COEF_RST;
			lp_coef_q <= LP_COEF_RST;
			gate_q    <= GATE_RST;
			knee_q    <= KNEE_LEVEL_RST;
			slope_q   <= KNEE_SLOPE_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_GAIN:       gain_q    <= cfg.data[COEF_W-1:0];
				REG_HP_COEF:    hp_coef_q <= cfg.data[COEF_W-1:0];
				REG_LP_COEF:    lp_coef_q <= cfg.data[COEF_W-1:0];
				REG_GATE:       gate_q    <= cfg.data[MAG_W-1:0];
				REG_KNEE_LEVEL: knee_q    <= cfg.data[MAG_W-1:0];
				REG_KNEE_SLOPE: slope_q   <= cfg.data[COEF_W-1:0];
				default:        ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Sequencer and shared multiply-accumulate unit
	// ---------------------------------------------------------------
	assign accept       = sample.valid && ctrl.in_ready;
	assign sample.ready = ctrl.in_ready;
	assign out_free     = !out_valid_q || result.ready;

	agfg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.knee_hit (knee_hit),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	// Coefficient side of the multiplier
	always_comb begin
		case (ctrl.mac.coef_sel)
			CS_GAIN:   mul_a = MUL_A_W'(gain_q);
			CS_HP:     mul_a = MUL_A_W'(hp_coef_q);
			CS_LP:     mul_a = MUL_A_W'(lp_coef_q);
			CS_LP_INV: mul_a = COEF_ONE - MUL_A_W'(lp_coef_q);
			CS_SLOPE:  mul_a = MUL_A_W'(slope_q);
			default:   mul_a = '0;
		endcase
	end

	// Operand side: the raw sample, or the low or high half of the operand register
	always_comb begin
		case (ctrl.mac.opnd_sel)
			OS_SAMPLE: mul_b = MUL_B_W'(x_q);
			OS_LO:     mul_b = $signed({1'b0, op_q[SPLIT-1:0]});
			OS_HI:     mul_b = MUL_B_W'($signed(op_q[OP_W-1:SPLIT]));
			default:   mul_b = '0;
		endcase
	end

	agfg_mac u_mac (
		.clk    (clk),
		.mul_a  (mul_a),
		.mul_b  (mul_b),
		.acc_op (ctrl.mac.acc_op),
		.prod   (prod),
		.acc    (acc)
	);

	// Every accumulated product is floored back to the value scale
	assign acc_shr = acc >>> COEF_FRAC;

	// ---------------------------------------------------------------
	// Step arithmetic around the shared unit
	// ---------------------------------------------------------------
	// the product with the Q8.8 gain is shifted up to the internal fraction width
	assign s_new  = sat_val(ACC_W'(prod) <<< GAIN_SHIFT);
	assign diff   = OP_W'(hp_out_q) + OP_W'(s_new) - OP_W'(hp_in_q);
	assign hp_new = sat_val(acc_shr);
	assign lp_new = sat_val(acc_shr + ACC_W'(part_q));

	// Gate and knee decisions use the stored low-pass output
	assign lp_ext   = OP_W'(lp_last_q);
	assign lp_abs   = lp_ext[OP_W-1] ? -lp_ext : lp_ext;
	assign thr      = $signed(OP_W'(gate_q) << FRAC_BITS);
	assign knee     = $signed(OP_W'(knee_q) << FRAC_BITS);
	assign gated    = lp_abs < thr;
	assign hit_pos  = !gated && (lp_ext > knee);
	assign hit_neg  = !gated && (lp_ext < -knee);
	assign knee_hit = hit_pos || hit_neg;

	assign knee_base = kneg_q ? -knee : knee;
	assign knee_new  = sat_val(ACC_W'(knee_base) + acc_shr);

	// Truncate toward zero: bias negative values up before the shift
	assign trunc_bias = v_q[VAL_W-1] ? FRAC_MASK : '0;
	assign trunc_val  = (v_q + trunc_bias) >>> FRAC_BITS;

	always_comb begin
		if (trunc_val > RES_HI)
			res_new = RES_HI[SAMPLE_W-1:0];
		else if (trunc_val < RES_LO)
			res_new = RES_LO[SAMPLE_W-1:0];
		else
			res_new = trunc_val[SAMPLE_W-1:0];
	end

	// Filter history: restart clears it before the sample is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_in_q   <= '0;
			hp_out_q  <= '0;
			lp_last_q <= '0;
		end else if (accept && sample.restart) begin
			hp_in_q   <= '0;
			hp_out_q  <= '0;
			lp_last_q <= '0;
		end else begin
			if (ctrl.ld_hp) begin
				hp_in_q  <= s_q;
				hp_out_q <= hp_new;
			end
			if (ctrl.ld_lp)
				lp_last_q <= lp_new;
		end
	end

	// Working registers of the sample in flight
	always_ff @(posedge clk) begin
		if (accept)
			x_q <= sample.in_sample;
		if (ctrl.ld_diff) begin
			s_q  <= s_new;
			op_q <= diff;
		end
		// hand the old low-pass output to the multiplier once the high-pass halves are issued
		if (ctrl.ld_op_lp)
			op_q <= OP_W'(lp_last_q);
		if (ctrl.ld_hp)
			op_q <= OP_W'(hp_new);
		if (ctrl.ld_part)
			part_q <= acc_shr[PART_W-1:0];
		if (ctrl.ld_gate) begin
			v_q    <= gated ? '0 : lp_last_q;
			kneg_q <= hit_neg;
			op_q   <= hit_pos ? lp_ext - knee : lp_ext + knee;
		end
		if (ctrl.ld_knee)
			v_q <= knee_new;
		if (ctrl.ld_trunc)
			res_q <= res_new;
	end

	// ---------------------------------------------------------------
	// Chunk peak and count
	// ---------------------------------------------------------------
	assign pk_ctl.clear  = accept && sample.restart;
	assign pk_ctl.update = ctrl.peak_upd;
	assign pk_ctl.finish = ctrl.out_load;

	agfg_peak u_peak (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pk_ctl),
		.res    (res_q),
		.done   (pk_done),
		.level  (pk_level)
	);

	// ---------------------------------------------------------------
	// Output register: one result beat per sample
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctrl.out_load)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			out_sample_q <= res_q;
			out_byte_q   <= res_q[SAMPLE_W-1:SAMPLE_W-BYTE_W];
			chunk_done_q <= pk_done;
			peak_level_q <= pk_done ? pk_level : '0;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.out_sample = out_sample_q;
	assign result.out_byte   = out_byte_q;
	assign result.chunk_done = chunk_done_q;
	assign result.peak_level = peak_level_q;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the audio gain, filter, gate, soft-knee and chunk-peak unit.
`timescale 1ns / 100ps

module testbench import agfg_pkg::*; ();

	// Timing of the run
	localparam int DRAIN_CYCLES = 40;    // idle clocks after the last result of a phase
	localparam int STALL_LIMIT  = 2000;  // cycles with no beat on any channel before giving up
	localparam int IDLE_PCT     = 11;

	// Indexes past the last register: writes there must leave everything unchanged
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// Internal fixed-point range of the chain
	localparam longint VAL_MAX = (longint'(1) <<< (VAL_W - 1)) - 1;
	localparam longint VAL_MIN = -(longint'(1) <<< (VAL_W - 1));

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] smp;
		logic                       rst;
	} mic_beat_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] smp;
		logic signed [BYTE_W-1:0]   byt;
		logic                       done;
		logic [LEVEL_W-1:0]         level;
	} chain_result_t;

	logic clk;
	logic arst_n;

	agfg_sample_if sample_ch ();
	agfg_result_if result_ch ();
	agfg_cfg_if    cfg_ch ();

	audio_gain_filter_gate_clip_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Register shadow: what the block should hold after every accepted write
	logic [COEF_W-1:0] gain_set   = GAIN_RST;
	logic [COEF_W-1:0] hp_alpha   = HP_COEF_RST;
	logic [COEF_W-1:0] lp_alpha   = LP_COEF_RST;
	logic [MAG_W-1:0]  gate_level = GATE_RST;
	logic [MAG_W-1:0]  knee_mag   = KNEE_LEVEL_RST;
	logic [COEF_W-1:0] knee_gain  = KNEE_SLOPE_RST;

	// Filter history and chunk tracking of the predictor
	longint            hp_prev_in  = 0;
	longint            hp_prev_out = 0;
	longint            lp_prev_out = 0;
	logic [PEAK_W-1:0] peak_hold   = '0;
	int                chunk_fill  = 0;

	mic_beat_t     mic_backlog[$];   // samples waiting for the driver
	chain_result_t expected_out[$];  // predicted result beats, oldest first

	mic_beat_t     nxt_beat;
	chain_result_t want;
	int            gap_left      = 0;
	int            beats_queued  = 0;
	int            results_seen  = 0;
	int            fail_count    = 0;
	int            stall_cycles  = 0;
	int            drift_level   = 0;
	logic          no_idle       = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Clamp to the 40-bit internal range after every step
	function automatic longint clamp_val(input longint v);
		if (v > VAL_MAX)
			return VAL_MAX;
		if (v < VAL_MIN)
			return VAL_MIN;
		return v;
	endfunction

	// Run one sample through the chain and advance the predictor state
	function automatic chain_result_t predict_chain(input logic signed [SAMPLE_W-1:0] smp,
	                                                input logic rst);
		chain_result_t r;
		longint        x, s, hp, lp, v, thr, knee, mag;
		int            pk;
		x = longint'(smp);
		if (rst) begin
			hp_prev_in  = 0;
			hp_prev_out = 0;
			lp_prev_out = 0;
			peak_hold   = '0;
			chunk_fill  = 0;
		end

		s  = clamp_val(x * longint'(gain_set) * (longint'(1) <<< GAIN_SHIFT));
		hp = clamp_val((longint'(hp_alpha) * (hp_prev_out + s - hp_prev_in)) >>> COEF_FRAC);
		hp_prev_in  = s;
		hp_prev_out = hp;

		lp = clamp_val(((longint'(lp_alpha) * hp) >>> COEF_FRAC) +
		               (((longint'(1) <<< COEF_FRAC) - longint'(lp_alpha)) * lp_prev_out
		                >>> COEF_FRAC));
		lp_prev_out = lp;

		// Gate on magnitude, then bend everything beyond the knee
		v   = lp;
		thr = longint'(gate_level) <<< FRAC_BITS;
		mag = (v < 0) ? -v : v;
		if (mag < thr)
			v = 0;
		knee = longint'(knee_mag) <<< FRAC_BITS;
		if (v > knee)
			v = clamp_val(knee + (((v - knee) * longint'(knee_gain)) >>> COEF_FRAC));
		else if (v < -knee)
			v = clamp_val(-knee + (((v + knee) * longint'(knee_gain)) >>> COEF_FRAC));

		// Truncate toward zero, then saturate to the sample width
		v = (v >= 0) ? (v >>> FRAC_BITS) : -((-v) >>> FRAC_BITS);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		r.smp = v[SAMPLE_W-1:0];
		r.byt = r.smp[SAMPLE_W-1:SAMPLE_W-BYTE_W];

		// The most negative sample counts as full scale for the peak
		pk = (v < 0) ? int'(-v) : int'(v);
		if (pk > 32767)
			pk = 32767;
		if (pk > int'(peak_hold))
			peak_hold = pk[PEAK_W-1:0];

		chunk_fill++;
		r.done  = (chunk_fill >= CHUNK_SAMPLES);
		r.level = '0;
		if (r.done) begin
			r.level    = LEVEL_W'((int'(peak_hold) * 255) / 32767);
			peak_hold  = '0;
			chunk_fill = 0;
		end
		return r;
	endfunction

	// Random sample content: full range, quiet noise, rails and a slow wander
	function automatic logic signed [SAMPLE_W-1:0] pick_mic_sample();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 35)
			return SAMPLE_W'($urandom_range(0, 65535));
		if (sel < 60)
			return SAMPLE_W'($signed($urandom_range(0, 1200)) - 600);
		if (sel < 75) begin
			case ($urandom_range(0, 4))
				0: return 16'sh8000;
				1: return 16'sh7FFF;
				2: return 16'sh0000;
				3: return 16'shFFFF;
				default: return 16'sh0001;
			endcase
		end
		drift_level += $signed($urandom_range(0, 4000)) - 2000;
		if (drift_level > 32767)
			drift_level = 32767;
		if (drift_level < -32768)
			drift_level = -32768;
		return SAMPLE_W'(drift_level);
	endfunction

	task automatic push_beat(input logic signed [SAMPLE_W-1:0] smp, input logic rst);
		mic_backlog.push_back('{smp: smp, rst: rst});
		beats_queued++;
	endtask

	// One register write; update the shadow on the accepting edge
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		case (cfg_reg_t'(idx))
			REG_GAIN:       gain_set   = val[COEF_W-1:0];
			REG_HP_COEF:    hp_alpha   = val[COEF_W-1:0];
			REG_LP_COEF:    lp_alpha   = val[COEF_W-1:0];
			REG_GATE:       gate_level = val[MAG_W-1:0];
			REG_KNEE_LEVEL: knee_mag   = val[MAG_W-1:0];
			REG_KNEE_SLOPE: knee_gain  = val[COEF_W-1:0];
			default: ;
		endcase
	endtask

	// Write all six registers; random junk above the 16-bit ones must be dropped
	task automatic program_setting(input logic [COEF_W-1:0] g, input logic [COEF_W-1:0] ha,
	                               input logic [COEF_W-1:0] la, input logic [MAG_W-1:0] gt,
	                               input logic [MAG_W-1:0] kl, input logic [COEF_W-1:0] ks);
		write_reg(REG_GAIN,       {4'($urandom_range(0, 15)), g});
		write_reg(REG_HP_COEF,    {4'($urandom_range(0, 15)), ha});
		write_reg(REG_LP_COEF,    {4'($urandom_range(0, 15)), la});
		write_reg(REG_GATE,       gt);
		write_reg(REG_KNEE_LEVEL, kl);
		write_reg(REG_KNEE_SLOPE, {4'($urandom_range(0, 15)), ks});
	endtask

	// Hold until every queued sample has come back, then let the pipeline settle
	task automatic wait_drain();
		while (results_seen < beats_queued)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Sample driver: present the next backlog beat, hold it until ready, insert random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready)
				expected_out.push_back(predict_chain(sample_ch.in_sample, sample_ch.restart));
			if (!sample_ch.valid || sample_ch.ready) begin
				if (gap_left > 0) begin
					gap_left        <= gap_left - 1;
					sample_ch.valid <= 1'b0;
				end else if (mic_backlog.size() != 0 && !no_idle &&
				             $urandom_range(0, 99) < IDLE_PCT) begin
					// Idle for a random stretch so gaps land on every step of the chain
					gap_left        <= $urandom_range(0, 19);
					sample_ch.valid <= 1'b0;
				end else if (mic_backlog.size() != 0) begin
					nxt_beat            = mic_backlog.pop_front();
					sample_ch.in_sample <= nxt_beat.smp;
					sample_ch.restart   <= nxt_beat.rst;
					sample_ch.valid     <= 1'b1;
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: stall at random, compare each accepted beat with the oldest prediction
	always @(posedge clk) begin
		result_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (expected_out.size() == 0) begin
				$error("result beat with no sample outstanding: out_sample %0d",
				       result_ch.out_sample);
				fail_count++;
			end else begin
				want = expected_out.pop_front();
				if (result_ch.out_sample !== want.smp) begin
					$error("out_sample: expected %0d, actual %0d", want.smp, result_ch.out_sample);
					fail_count++;
				end
				if (result_ch.out_byte !== want.byt) begin
					$error("out_byte: expected %0d, actual %0d", want.byt, result_ch.out_byte);
					fail_count++;
				end
				if (result_ch.chunk_done !== want.done) begin
					$error("chunk_done: expected %0d, actual %0d", want.done,
					       result_ch.chunk_done);
					fail_count++;
				end
				if (result_ch.peak_level !== want.level) begin
					$error("peak_level: expected %0d, actual %0d", want.level,
					       result_ch.peak_level);
					fail_count++;
				end
			end
		end
	end

	// Count cycles in which no channel moves a beat
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
		    (cfg_ch.valid && cfg_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin : watchdog
		wait (stall_cycles >= STALL_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		logic [COEF_W-1:0] g, ha, la, ks;
		logic [MAG_W-1:0]  gt, kl;
		int                n_items, restart_pct;

		// Drive every input to a known value from time zero
		arst_n              = 1'b0;
		sample_ch.valid     = 1'b0;
		sample_ch.in_sample = '0;
		sample_ch.restart   = 1'b0;
		result_ch.ready     = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = '0;
		cfg_ch.data         = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Writes past the last register must not disturb the defaults used below
		write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom_range(0, 1048575)));
		write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 1048575)));

		// Directed beats at reset settings: rails, sign flips, tiny values, restart mid-stream
		push_beat(16'sd0, 1'b1);      push_beat(16'sd32767, 1'b0);  push_beat(16'sd32767, 1'b0);
		push_beat(-16'sd32768, 1'b0); push_beat(-16'sd32768, 1'b0); push_beat(16'sd32767, 1'b0);
		push_beat(16'sd0, 1'b0);      push_beat(16'sd1, 1'b0);      push_beat(-16'sd1, 1'b0);
		push_beat(16'sd10, 1'b0);     push_beat(-16'sd10, 1'b0);    push_beat(16'sd2000, 1'b0);
		push_beat(-16'sd2000, 1'b0);  push_beat(-16'sd32768, 1'b1); push_beat(16'sd32767, 1'b0);
		push_beat(16'sd0, 1'b0);      push_beat(-16'sd32768, 1'b0); push_beat(-16'sd32768, 1'b0);
		push_beat(16'sd5, 1'b0);      push_beat(16'sd0, 1'b1);
		wait_drain();

		// Random phases; the first seven carry no restart so one full chunk completes
		for (int phase = 0; phase < 9; phase++) begin
			g  = GAIN_RST;   ha = HP_COEF_RST;    la = LP_COEF_RST;
			gt = GATE_RST;   kl = KNEE_LEVEL_RST; ks = KNEE_SLOPE_RST;
			n_items     = (phase < 7) ? 150 : 100;
			restart_pct = (phase < 7) ? 0 : 6;
			case (phase)
				0: begin
					// Every coefficient at its top: drive the chain into saturation
					g = '1; ha = '1; la = '1; gt = '0; kl = '0; ks = '1;
				end
				1: g = '0;
				2: begin
					g = 16'd256; ha = '0; la = '0; gt = '0;
				end
				4: begin
					// Gate and knee at their top: everything is silenced
					g = 16'd1024; ha = '1; la = '1; gt = '1; kl = '1; ks = '0;
				end
				5: begin
					g = '1; ha = 16'd32768; la = '1; gt = '0; kl = 20'd100; ks = '0;
				end
				6: ;
				default: begin
					g  = COEF_W'($urandom_range(0, 65535));
					ha = COEF_W'($urandom_range(0, 65535));
					la = COEF_W'($urandom_range(0, 65535));
					ks = COEF_W'($urandom_range(0, 65535));
					gt = ($urandom_range(0, 3) == 0) ? MAG_W'($urandom_range(0, 1048575))
					                                 : MAG_W'($urandom_range(0, 3000));
					kl = ($urandom_range(0, 3) == 0) ? MAG_W'($urandom_range(0, 1048575))
					                                 : MAG_W'($urandom_range(0, 40000));
				end
			endcase
			program_setting(g, ha, la, gt, kl, ks);
			if (phase == 8)
				write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 1048575)));

			// One phase runs flat out on both sides
			@(posedge clk);
			no_idle <= (phase == 3);
			for (int i = 0; i < n_items; i++)
				push_beat(pick_mic_sample(), $urandom_range(0, 99) < restart_pct);
			wait_drain();
		end

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
